// ===== rtl/svsl_pkg.sv =====
// Shared types, constants and command codes for the two-axis servo slew limiter.
package svsl_pkg;

  // Angle limits in whole degrees
  localparam logic [7:0] ANGLE_MAX = 8'd180;
  localparam logic [7:0] ANGLE_MID = 8'd90;

  // Compass arithmetic, degrees x16
  localparam logic signed [14:0] FULL_TURN_X16 = 15'sd5760;
  localparam logic signed [14:0] HALF_TURN_X16 = 15'sd2880;
  localparam logic signed [14:0] ERR_LIMIT_X16 = 15'sd720;

  // Input opcodes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_SET_AZ  = 3'd1;
  localparam logic [2:0] OP_SET_EL  = 3'd2;
  localparam logic [2:0] OP_NUDGE_L = 3'd3;
  localparam logic [2:0] OP_NUDGE_R = 3'd4;
  localparam logic [2:0] OP_COMPASS = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_ELEV_EN   = 2'd0;
  localparam logic [1:0] REG_NUDGE     = 2'd1;
  localparam logic [1:0] REG_SLEW      = 2'd2;
  localparam logic [1:0] REG_INTERVAL  = 2'd3;

  // Register reset values
  localparam logic [7:0]  NUDGE_RST    = 8'd10;
  localparam logic [7:0]  SLEW_RST     = 8'd3;
  localparam logic [15:0] INTERVAL_RST = 16'd40;

  localparam int QUEUE_DEPTH = 2;

  // Decoded command kinds; compass collapses into a set of azimuth
  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_SET_AZ  = 3'd1,
    CMD_SET_EL  = 3'd2,
    CMD_NUDGE_L = 3'd3,
    CMD_NUDGE_R = 3'd4,
    CMD_NOP     = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] value;   // clamped angle for a set
  } cmd_t;

  typedef struct packed {
    logic        elevation_enable;
    logic [7:0]  nudge_step;
    logic [7:0]  slew_step;
    logic [15:0] move_interval;
  } cfg_t;

endpackage

// ===== rtl/svsl_front.sv =====
// Front end: takes input words, decodes them and works out any absolute target.
module svsl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          opcode,
  input  logic signed [15:0]  angle,
  input  logic [12:0]         compass_heading,
  input  logic [12:0]         sun_azimuth,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output svsl_pkg::cmd_t      cmd
);
  import svsl_pkg::*;

  logic              f_valid;
  logic              f_valid_next;
  cmd_t              f_cmd;
  cmd_t              dec;
  logic [7:0]        set_angle;
  logic [7:0]        compass_angle;
  logic signed [14:0] e0, e1, e2, e3, emag;
  logic [5:0]        q;

  always_comb begin
    if (angle < 16'sd0) begin
      set_angle = 8'd0;
    end else if (angle > $signed({8'd0, ANGLE_MAX})) begin
      set_angle = ANGLE_MAX;
    end else begin
      set_angle = angle[7:0];
    end
  end

  // Heading error, wrapped once each way, clamped, truncated toward zero
  always_comb begin
    e0 = $signed({2'b00, sun_azimuth}) - $signed({2'b00, compass_heading});
    e1 = (e0 < -HALF_TURN_X16) ? e0 + FULL_TURN_X16 : e0;
    e2 = (e1 > HALF_TURN_X16) ? e1 - FULL_TURN_X16 : e1;
    if (e2 < -ERR_LIMIT_X16) begin
      e3 = -ERR_LIMIT_X16;
    end else if (e2 > ERR_LIMIT_X16) begin
      e3 = ERR_LIMIT_X16;
    end else begin
      e3 = e2;
    end
    emag = e3[14] ? -e3 : e3;
    q    = emag[9:4];
    compass_angle = e3[14] ? ANGLE_MID - {2'b00, q} : ANGLE_MID + {2'b00, q};
  end

  always_comb begin
    dec.value = set_angle;
    case (opcode)
      OP_TICK:    dec.kind = CMD_TICK;
      OP_SET_AZ:  dec.kind = CMD_SET_AZ;
      OP_SET_EL:  dec.kind = CMD_SET_EL;
      OP_NUDGE_L: dec.kind = CMD_NUDGE_L;
      OP_NUDGE_R: dec.kind = CMD_NUDGE_R;
      OP_COMPASS: begin
        dec.kind  = CMD_SET_AZ;
        dec.value = compass_angle;
      end
      default:    dec.kind = CMD_NOP;
    endcase
  end

  assign in_ready = !f_valid || cmd_ready;

  always_comb begin
    if (in_valid && in_ready) begin
      f_valid_next = 1'b1;
    end else if (cmd_ready) begin
      f_valid_next = 1'b0;
    end else begin
      f_valid_next = f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_cmd <= dec;
    end
  end

  assign cmd_valid = f_valid;
  assign cmd       = f_cmd;

endmodule

// ===== rtl/svsl_queue.sv =====
// Two-entry command queue between the front and back ends.
module svsl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  svsl_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output svsl_pkg::cmd_t rd_cmd
);
  import svsl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t               slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               push, pop;

  assign wr_ready = (count != QUEUE_DEPTH[PTR_W:0]);
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

// ===== rtl/svsl_back.sv =====
// Back end: holds axis state, executes commands, registers the result word.
module svsl_back (
  input  logic           clk,
  input  logic           rst,
  input  svsl_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  svsl_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     azimuth_angle,
  output logic [7:0]     elevation_angle,
  output logic [7:0]     azimuth_target,
  output logic [7:0]     elevation_target,
  output logic           azimuth_moved,
  output logic           elevation_moved
);
  import svsl_pkg::*;

  logic [7:0]  az_now, az_goal, el_now, el_goal;
  logic [7:0]  az_now_next, az_goal_next, el_now_next, el_goal_next;
  logic [15:0] ticks, ticks_next, ticks_inc;
  logic        az_mv, el_mv, az_mv_next, el_mv_next;
  logic        fire, take;
  logic [7:0]  az_slew, el_slew;
  logic        az_off, el_off;
  logic signed [9:0] nudged;
  logic [7:0]  nudge_clamped;

  // One axis step toward its goal; off flags an axis not on target
  function automatic logic [8:0] slew_axis(input logic [7:0] now, input logic [7:0] goal,
                                           input logic [7:0] step);
    logic [7:0] mag;
    logic [7:0] res;
    mag = (goal > now) ? goal - now : now - goal;
    if (mag <= step) begin
      res = goal;
    end else if (goal > now) begin
      res = now + step;
    end else begin
      res = now - step;
    end
    return {goal != now, res};
  endfunction

  assign cmd_ready = !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;

  assign ticks_inc = (ticks != 16'hFFFF) ? ticks + 16'd1 : ticks;
  assign fire      = (ticks_inc >= cfg.move_interval);
  assign {az_off, az_slew} = slew_axis(az_now, az_goal, cfg.slew_step);
  assign {el_off, el_slew} = slew_axis(el_now, el_goal, cfg.slew_step);

  always_comb begin
    if (cmd.kind == CMD_NUDGE_L) begin
      nudged = $signed({2'b00, az_goal}) - $signed({2'b00, cfg.nudge_step});
    end else begin
      nudged = $signed({2'b00, az_goal}) + $signed({2'b00, cfg.nudge_step});
    end
    if (nudged < 10'sd0) begin
      nudge_clamped = 8'd0;
    end else if (nudged > $signed({2'b00, ANGLE_MAX})) begin
      nudge_clamped = ANGLE_MAX;
    end else begin
      nudge_clamped = nudged[7:0];
    end
  end

  always_comb begin
    az_now_next  = az_now;
    az_goal_next = az_goal;
    el_now_next  = el_now;
    el_goal_next = el_goal;
    ticks_next   = ticks;
    az_mv_next   = 1'b0;
    el_mv_next   = 1'b0;
    case (cmd.kind)
      CMD_TICK: begin
        ticks_next = fire ? 16'd0 : ticks_inc;
        if (fire) begin
          az_now_next = az_slew;
          az_mv_next  = az_off;
          if (cfg.elevation_enable) begin
            el_now_next = el_slew;
            el_mv_next  = el_off;
          end
        end
      end
      CMD_SET_AZ: az_goal_next = cmd.value;
      CMD_SET_EL: begin
        if (cfg.elevation_enable) begin
          el_goal_next = cmd.value;
        end
      end
      CMD_NUDGE_L, CMD_NUDGE_R: az_goal_next = nudge_clamped;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      az_now    <= ANGLE_MID;
      az_goal   <= ANGLE_MID;
      el_now    <= ANGLE_MID;
      el_goal   <= ANGLE_MID;
      ticks     <= '0;
      az_mv     <= 1'b0;
      el_mv     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        az_now    <= az_now_next;
        az_goal   <= az_goal_next;
        el_now    <= el_now_next;
        el_goal   <= el_goal_next;
        ticks     <= ticks_next;
        az_mv     <= az_mv_next;
        el_mv     <= el_mv_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // State only changes when the result slot is free, so it is the result
  assign azimuth_angle    = az_now;
  assign elevation_angle  = el_now;
  assign azimuth_target   = az_goal;
  assign elevation_target = el_goal;
  assign azimuth_moved    = az_mv;
  assign elevation_moved  = el_mv;

endmodule

// ===== rtl/two_axis_servo_slew_limiter.sv =====
// Top level of the two-axis servo slew limiter: config registers, front, queue, back.
// Accepts one input word per clock while the output keeps up and returns exactly one
// result word per input, in order. The accepting edge loads the decode register; a
// word then passes through the two-entry queue and the execute stage, whose state
// registers double as the result register. With the output side ready, throughput
// is one word per cycle; a stalled output fills the queue and then backs up to
// in_ready. Opcodes: 0 tick (one millisecond), 1 set azimuth, 2 set elevation, 3/4
// nudge azimuth left/right, 5 compass-derived azimuth, 6/7 no operation. Angles are
// whole degrees clamped to 0..180; compass inputs are degrees x16. Every
// move_interval ticks the azimuth axis, and the elevation axis when elevation_enable
// is set, step toward their targets by at most slew_step. Configuration (index 0
// elevation_enable, 1 nudge_step, 2 slew_step, 3 move_interval) is always ready
// and takes effect on the next word; write it only while the block is idle.
module two_axis_servo_slew_limiter (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input word channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [15:0] angle,
  input  logic [12:0]        compass_heading,
  input  logic [12:0]        sun_azimuth,
  // result word channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         azimuth_angle,
  output logic [7:0]         elevation_angle,
  output logic [7:0]         azimuth_target,
  output logic [7:0]         elevation_target,
  output logic               azimuth_moved,
  output logic               elevation_moved
);
  import svsl_pkg::*;

  cfg_t  cfg;
  logic  f_valid, f_ready;
  cmd_t  f_cmd;
  logic  q_valid, q_ready;
  cmd_t  q_cmd;

  // Configuration registers; writes are never stalled
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.elevation_enable <= 1'b0;
      cfg.nudge_step       <= NUDGE_RST;
      cfg.slew_step        <= SLEW_RST;
      cfg.move_interval    <= INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ELEV_EN:  cfg.elevation_enable <= cfg_data[0];
        REG_NUDGE:    cfg.nudge_step       <= cfg_data[7:0];
        REG_SLEW:     cfg.slew_step        <= cfg_data[7:0];
        REG_INTERVAL: cfg.move_interval    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode and compass arithmetic
  svsl_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .angle           (angle),
    .compass_heading (compass_heading),
    .sun_azimuth     (sun_azimuth),
    .cmd_valid       (f_valid),
    .cmd_ready       (f_ready),
    .cmd             (f_cmd)
  );

  // Decouples decode from execution
  svsl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  // Axis state, tick counter and slew
  svsl_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd_valid        (q_valid),
    .cmd_ready        (q_ready),
    .cmd              (q_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .azimuth_angle    (azimuth_angle),
    .elevation_angle  (elevation_angle),
    .azimuth_target   (azimuth_target),
    .elevation_target (elevation_target),
    .azimuth_moved    (azimuth_moved),
    .elevation_moved  (elevation_moved)
  );

`ifndef NO_ASSERTIONS
  // Elevation can only report a move while the axis is enabled
  a_el_moved_enabled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && elevation_moved) |-> cfg.elevation_enable)
    else $error("elevation moved while disabled");

  // Every angle and target stays inside the servo range
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    (azimuth_angle <= ANGLE_MAX) && (elevation_angle <= ANGLE_MAX) &&
    (azimuth_target <= ANGLE_MAX) && (elevation_target <= ANGLE_MAX))
    else $error("angle out of range");

  // A freshly executed word with a moved flag leaves the axis somewhere new
  a_az_moved_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && azimuth_moved && cfg.slew_step != 8'd0 && $past(q_valid && q_ready)) |->
      (azimuth_angle != $past(azimuth_angle) || $past(rst)))
    else $error("azimuth moved flag without a change");

  // No result is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");
`endif

endmodule
